### rtl/lfv_pkg.sv
// Shared types, codes and helpers for the LIN frame validator.
package lfv_pkg;

   localparam int MAX_DATA_BYTES = 8;
   localparam int COUNT_W = 4;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_HEADER = 2'd0;
   localparam opcode_type OP_DATA   = 2'd1;
   localparam opcode_type OP_CHECK  = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_DATA_BYTES);

   // One input word as held in the input register.
   typedef struct packed {
      opcode_type  opcode;
      logic [31:0] frame_id;
      logic        enhanced_mode;
      logic [7:0]  byte_value;
   } item_type;

   // One verdict word.
   typedef struct packed {
      logic               frame_good;
      logic               parity_good;
      logic               sum_good;
      logic [7:0]         computed_sum;
      logic [COUNT_W-1:0] data_count;
      logic               too_long;
   } result_type;

   // Protected ID parity check; extended IDs above one byte always pass.
   function automatic logic parity_ok(input logic [31:0] id);
      logic [5:0] b;
      logic       p0;
      logic       p1;
      b  = id[5:0];
      p0 = b[0] ^ b[1] ^ b[2] ^ b[4];
      p1 = ~(b[1] ^ b[3] ^ b[4] ^ b[5]);
      if (id[31:8] != 24'd0) begin
         return 1'b1;
      end
      return ({p1, p0, b} == id[7:0]);
   endfunction

endpackage

### rtl/lfv_frame_engine.sv
// Frame state (running sum, parity, count, overflow) and verdict logic.
module lfv_frame_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  lfv_pkg::item_type   item,
   output logic                result_fire,
   output lfv_pkg::result_type result
);

   logic [7:0]                  sum_ff, sum_in;
   logic                        parity_ff, parity_in;
   logic [lfv_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        over_ff, over_in;
   logic [7:0]                  id_sum;
   logic [7:0]                  inv_sum;
   logic                        sum_match;

   assign id_sum = item.frame_id[31:24] + item.frame_id[23:16]
                 + item.frame_id[15:8]  + item.frame_id[7:0];
   assign inv_sum   = ~sum_ff;
   assign sum_match = (item.byte_value == inv_sum);

   always_comb begin
      sum_in    = sum_ff;
      parity_in = parity_ff;
      count_in  = count_ff;
      over_in   = over_ff;
      if (step_en) begin
         unique case (item.opcode)
            lfv_pkg::OP_HEADER: begin
               parity_in = lfv_pkg::parity_ok(item.frame_id);
               sum_in    = item.enhanced_mode ? id_sum : 8'd0;
               count_in  = '0;
               over_in   = 1'b0;
            end
            lfv_pkg::OP_DATA: begin
               sum_in = sum_ff + item.byte_value;
               if (count_ff < lfv_pkg::COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  over_in = 1'b1;
               end
            end
            lfv_pkg::OP_CHECK: begin
               sum_in    = 8'd0;
               parity_in = 1'b0;
               count_in  = '0;
               over_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= 8'd0;
         parity_ff <= 1'b0;
         count_ff  <= '0;
         over_ff   <= 1'b0;
      end else begin
         sum_ff    <= sum_in;
         parity_ff <= parity_in;
         count_ff  <= count_in;
         over_ff   <= over_in;
      end
   end

   assign result_fire = step_en && (item.opcode == lfv_pkg::OP_CHECK);

   always_comb begin
      result.frame_good   = parity_ff & sum_match;
      result.parity_good  = parity_ff;
      result.sum_good     = sum_match;
      result.computed_sum = inv_sum;
      result.data_count   = count_ff;
      result.too_long     = over_ff;
   end

endmodule

### rtl/lin_frame_validator_core.sv
// Top level of the LIN frame validator: input register, frame engine, result register.
// Path: a checksum word accepted into the input register passes through the frame engine
//   into the result register, which drives its verdict on rsp_ until it is taken.
// Throughput: one word per cycle; a checksum word waits in the input register only
//   while the result register holds a verdict that has not been taken.
// Reset (synchronous, active high) empties both registers and clears the frame state
//   to a zero sum, zero count, no parity, no overflow.
// Header and data words produce no response word; opcode 3 is dropped.
module lin_frame_validator_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic [31:0]                 req_frame_id,
   input  logic                        req_enhanced_mode,
   input  logic [7:0]                  req_byte_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_frame_good,
   output logic                        rsp_parity_good,
   output logic                        rsp_sum_good,
   output logic [7:0]                  rsp_computed_sum,
   output logic [lfv_pkg::COUNT_W-1:0] rsp_data_count,
   output logic                        rsp_too_long
);

   // input register
   logic                in_valid_ff, in_valid_in;
   lfv_pkg::item_type   in_item_ff;
   logic                step_en;
   logic                result_fire;
   lfv_pkg::result_type result;
   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   lfv_pkg::result_type rsp_ff;

   // The held word moves on unless it is a checksum and the result slot is full.
   assign step_en = in_valid_ff
                  && ((in_item_ff.opcode != lfv_pkg::OP_CHECK) || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || step_en;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.opcode        <= req_opcode;
         in_item_ff.frame_id      <= req_frame_id;
         in_item_ff.enhanced_mode <= req_enhanced_mode;
         in_item_ff.byte_value    <= req_byte_value;
      end
   end

   lfv_frame_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .item        (in_item_ff),
      .result_fire (result_fire),
      .result      (result)
   );

   // Result slot: load on a verdict, empty once taken.
   always_comb begin
      if (result_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_good   = rsp_ff.frame_good;
   assign rsp_parity_good  = rsp_ff.parity_good;
   assign rsp_sum_good     = rsp_ff.sum_good;
   assign rsp_computed_sum = rsp_ff.computed_sum;
   assign rsp_data_count   = rsp_ff.data_count;
   assign rsp_too_long     = rsp_ff.too_long;

   // A verdict never overwrites one still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !result_fire)
      else $error("verdict overwritten before it was taken");

   // Overflow is only reported with the count at its ceiling.
   a_too_long_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_long) |-> (rsp_data_count == lfv_pkg::COUNT_MAX))
      else $error("too_long without a full data count");

   // Count never passes the ceiling.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data_count <= lfv_pkg::COUNT_MAX))
      else $error("data count past maximum");

   // A checksum word held back is released once the result slot drains.
   a_check_moves: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid_ff) |-> step_en)
      else $error("input word stalled with an empty result slot");

endmodule

### tb/tb_lin_frame_validator_core.sv
// Self-checking testbench for the LIN frame validator core.
`timescale 1ns / 1ps

module tb_lin_frame_validator_core;

   // opcode 3 has no name in the package; the core drops it
   localparam lfv_pkg::opcode_type OP_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 1900;
   localparam int TAIL_CYCLES  = 10;

   logic                        clock;
   logic                        reset             = 1'b1;
   logic                        req_valid         = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_opcode        = lfv_pkg::OP_HEADER;
   logic [31:0]                 req_frame_id      = 32'h0;
   logic                        req_enhanced_mode = 1'b0;
   logic [7:0]                  req_byte_value    = 8'h00;
   logic                        rsp_valid;
   logic                        rsp_ready         = 1'b0;
   logic                        rsp_frame_good;
   logic                        rsp_parity_good;
   logic                        rsp_sum_good;
   logic [7:0]                  rsp_computed_sum;
   logic [lfv_pkg::COUNT_W-1:0] rsp_data_count;
   logic                        rsp_too_long;

   lin_frame_validator_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_frame_id      (req_frame_id),
      .req_enhanced_mode (req_enhanced_mode),
      .req_byte_value    (req_byte_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_good    (rsp_frame_good),
      .rsp_parity_good   (rsp_parity_good),
      .rsp_sum_good      (rsp_sum_good),
      .rsp_computed_sum  (rsp_computed_sum),
      .rsp_data_count    (rsp_data_count),
      .rsp_too_long      (rsp_too_long)
   );

   // Frame tracker state: mirrors the core's running sum, parity, count, overflow.
   logic [7:0]                  sum_acc       = 8'h00;
   logic                        pid_ok        = 1'b0;
   logic [lfv_pkg::COUNT_W-1:0] count_acc     = '0;
   logic                        overflow_seen = 1'b0;

   lfv_pkg::result_type verdict_q[$];   // verdicts owed by the core, oldest first
   int error_count = 0;
   int word_count  = 0;        // accepted words, opcode 3 excluded
   bit tx_idle_on  = 1'b1;
   bit rx_idle_on  = 1'b1;
   int rx_hold     = 0;
   lfv_pkg::result_type seen_v;
   lfv_pkg::result_type want_v;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #4_000_000;
      $display("[lin_frame_validator_core] ERROR");
      $finish;
   end

   function automatic void report_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   // Gap length: mostly none, some short, a few long.
   function automatic int pick_gap(input bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Protected ID from its six identifier bits.
   function automatic logic [7:0] make_pid(input logic [5:0] b);
      return {~(b[1] ^ b[3] ^ b[4] ^ b[5]), b[0] ^ b[1] ^ b[2] ^ b[4], b};
   endfunction

   // Advance the frame tracker by one accepted word; checksum words owe a verdict.
   task automatic lin_track(input lfv_pkg::opcode_type op, input logic [31:0] id,
                            input logic enh, input logic [7:0] val);
      lfv_pkg::result_type v;
      case (op)
         lfv_pkg::OP_HEADER: begin
            // extended IDs skip the parity check
            pid_ok        = (id[31:8] != 24'd0) || (make_pid(id[5:0]) == id[7:0]);
            sum_acc       = enh ? id[31:24] + id[23:16] + id[15:8] + id[7:0] : 8'h00;
            count_acc     = '0;
            overflow_seen = 1'b0;
         end
         lfv_pkg::OP_DATA: begin
            sum_acc = sum_acc + val;   // modulo 256, no carry fold
            if (count_acc < lfv_pkg::COUNT_MAX) begin
               count_acc = count_acc + 1'b1;
            end else begin
               overflow_seen = 1'b1;
            end
         end
         lfv_pkg::OP_CHECK: begin
            v.computed_sum = ~sum_acc;
            v.sum_good     = (val == v.computed_sum);
            v.parity_good  = pid_ok;
            v.frame_good   = pid_ok & v.sum_good;
            v.data_count   = count_acc;
            v.too_long     = overflow_seen;
            verdict_q.push_back(v);
            sum_acc       = 8'h00;
            pid_ok        = 1'b0;
            count_acc     = '0;
            overflow_seen = 1'b0;
         end
         default: begin
         end
      endcase
   endtask

   // Present one word, hold it until the core takes it, then track it.
   task automatic send_word(input lfv_pkg::opcode_type op, input logic [31:0] id,
                            input logic enh, input logic [7:0] val);
      int gap;
      bit taken;
      gap = pick_gap(tx_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_frame_id      <= id;
      req_enhanced_mode <= enh;
      req_byte_value    <= val;
      // ready is settled mid-cycle and holds up to the next rising edge
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end
      lin_track(op, id, enh, val);
      if (op != OP_UNUSED) begin
         word_count++;
      end
   endtask

   // Sender goes quiet until every owed verdict has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (verdict_q.size() != 0);
   endtask

   // Response side: random ready pattern, and the check of every verdict taken.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_v.frame_good   = rsp_frame_good;
            seen_v.parity_good  = rsp_parity_good;
            seen_v.sum_good     = rsp_sum_good;
            seen_v.computed_sum = rsp_computed_sum;
            seen_v.data_count   = rsp_data_count;
            seen_v.too_long     = rsp_too_long;
            if (verdict_q.size() == 0) begin
               report_error("verdict word with none owed");
            end else begin
               want_v = verdict_q.pop_front();
               if (seen_v.frame_good !== want_v.frame_good ||
                   seen_v.parity_good !== want_v.parity_good ||
                   seen_v.sum_good !== want_v.sum_good ||
                   seen_v.computed_sum !== want_v.computed_sum ||
                   seen_v.data_count !== want_v.data_count ||
                   seen_v.too_long !== want_v.too_long) begin
                  report_error($sformatf({"verdict mismatch: got good=%0b par=%0b sum=%0b ",
                     "cs=%02h cnt=%0d long=%0b, want good=%0b par=%0b sum=%0b cs=%02h ",
                     "cnt=%0d long=%0b"},
                     seen_v.frame_good, seen_v.parity_good, seen_v.sum_good,
                     seen_v.computed_sum, seen_v.data_count, seen_v.too_long,
                     want_v.frame_good, want_v.parity_good, want_v.sum_good,
                     want_v.computed_sum, want_v.data_count, want_v.too_long));
               end
            end
         end
         // alternate ready runs with stalls of random length
         if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
         end else if (rsp_ready) begin
            rx_hold   <= pick_gap(rx_idle_on);
            rsp_ready <= 1'b0;
         end else begin
            rx_hold   <= $urandom_range(0, 7);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Parity corner IDs: zero ID, all-ones six bits, all-ones extended ID.
   task automatic test_parity_extremes();
      send_word(lfv_pkg::OP_HEADER, 32'h0000_0000, 1'b0, 8'h00);
      send_word(lfv_pkg::OP_CHECK, 32'h0, 1'b0, 8'h00);          // wrong sum, bad parity
      send_word(lfv_pkg::OP_HEADER, {24'h0, make_pid(6'h3F)}, 1'b1, 8'h00);
      send_word(lfv_pkg::OP_DATA, 32'hFFFF_FFFF, 1'b1, 8'hFF);
      send_word(lfv_pkg::OP_CHECK, 32'h0, 1'b0, ~sum_acc);
      send_word(lfv_pkg::OP_HEADER, 32'hFFFF_FFFF, 1'b1, 8'hFF);
      send_word(lfv_pkg::OP_CHECK, 32'hFFFF_FFFF, 1'b1, ~sum_acc);
   endtask

   // Bad parity with a good sum is still reported per check.
   task automatic test_checksum_modes();
      send_word(lfv_pkg::OP_HEADER, 32'h0000_00D5, 1'b0, 8'h00);
      send_word(lfv_pkg::OP_DATA, 32'h0, 1'b0, 8'h80);
      send_word(lfv_pkg::OP_CHECK, 32'h0, 1'b0, ~sum_acc);
   endtask

   // Headerless frame, dropped opcode, restarted frame, too many data words.
   task automatic test_frame_corners();
      send_word(lfv_pkg::OP_DATA, 32'h0, 1'b0, 8'h12);
      send_word(lfv_pkg::OP_CHECK, 32'h0, 1'b0, ~sum_acc);
      send_word(lfv_pkg::OP_HEADER, {24'h0, make_pid(6'h15)}, 1'b1, 8'h00);
      send_word(lfv_pkg::OP_DATA, 32'h0, 1'b0, 8'h7E);
      send_word(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 8'hFF);
      send_word(lfv_pkg::OP_HEADER, 32'h1234_5678, 1'b1, 8'h00);
      send_word(lfv_pkg::OP_CHECK, 32'h0, 1'b0, ~sum_acc);
      send_word(lfv_pkg::OP_HEADER, {24'h0, make_pid(6'h2A)}, 1'b0, 8'h00);
      repeat (lfv_pkg::MAX_DATA_BYTES + 1) begin
         send_word(lfv_pkg::OP_DATA, $urandom, 1'($urandom), 8'($urandom));
      end
      send_word(lfv_pkg::OP_CHECK, 32'h0, 1'b0, ~sum_acc);
   endtask

   function automatic logic [31:0] pick_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return {24'h0, make_pid(6'($urandom))};
      end
      if (r < 75) begin
         return {24'h0, 8'($urandom)};
      end
      if (r < 90) begin
         return $urandom;
      end
      case ($urandom_range(0, 3))
         0:       return 32'h0000_0000;
         1:       return 32'h0000_00FF;
         2:       return 32'h0000_0100;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Mostly well-formed frames with random content; some noise and broken frames.
   task automatic test_random_frames();
      int stop_at;
      int next_switch;
      int next_pause;
      int kind;
      int n_data;
      stop_at     = word_count + RANDOM_WORDS;
      next_switch = word_count;
      next_pause  = word_count + 600;
      while (word_count < stop_at) begin
         if (word_count >= next_switch) begin
            tx_idle_on  = ($urandom_range(0, 4) != 0);
            rx_idle_on  = ($urandom_range(0, 4) != 0);
            next_switch = word_count + $urandom_range(100, 250);
         end
         if (word_count >= next_pause) begin
            drain_results();
            next_pause = word_count + 600;
         end
         kind   = $urandom_range(0, 99);
         n_data = ($urandom_range(0, 99) < 85)
                  ? $urandom_range(0, lfv_pkg::MAX_DATA_BYTES)
                  : $urandom_range(lfv_pkg::MAX_DATA_BYTES + 1, 12);
         if (kind < 88) begin
            if (kind < 80) begin
               send_word(lfv_pkg::OP_HEADER, pick_id(), 1'($urandom), 8'($urandom));
            end
            repeat (n_data) begin
               if ($urandom_range(0, 19) == 0) begin
                  send_word(OP_UNUSED, $urandom, 1'($urandom), 8'($urandom));
               end
               send_word(lfv_pkg::OP_DATA, $urandom, 1'($urandom), 8'($urandom));
            end
            send_word(lfv_pkg::OP_CHECK, $urandom, 1'($urandom),
                      ($urandom_range(0, 3) != 0) ? ~sum_acc : 8'($urandom));
         end else if (kind < 95) begin
            // frame cut off by the next header
            send_word(lfv_pkg::OP_HEADER, pick_id(), 1'($urandom), 8'($urandom));
            repeat ($urandom_range(0, 4)) begin
               send_word(lfv_pkg::OP_DATA, $urandom, 1'($urandom), 8'($urandom));
            end
         end else begin
            send_word(lfv_pkg::opcode_type'($urandom_range(0, 3)), $urandom, 1'($urandom),
                      8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_parity_extremes();
      test_checksum_modes();
      test_frame_corners();
      test_random_frames();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (verdict_q.size() != 0) begin
         report_error("verdicts still owed at end of run");
      end
      if (error_count == 0) begin
         $display("[lin_frame_validator_core] OK");
      end else begin
         $display("[lin_frame_validator_core] ERROR");
      end
      $finish;
   end

endmodule
